>>> hw/rtl/assert_macros.svh
// assertion macros shared by the biquad filter modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define BQF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define BQF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/bqf_pkg.sv
// shared types and constants of the biquad filter
package bqf_pkg;

  localparam int COEF_BITS      = 32;
  localparam int OFFSET_BITS    = 16;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_FF0   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_FF1   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_FF2   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_FB1   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_FB2   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OUT_OFFSET = 3'd5;

  typedef struct packed {
    logic signed [COEF_BITS-1:0]   ff0;
    logic signed [COEF_BITS-1:0]   ff1;
    logic signed [COEF_BITS-1:0]   ff2;
    logic signed [COEF_BITS-1:0]   fb1;
    logic signed [COEF_BITS-1:0]   fb2;
    logic signed [OFFSET_BITS-1:0] offset;
  } bqf_cfg_t;

endpackage

>>> hw/rtl/bqf_regs.sv
// configuration registers: coefficients and output offset
module bqf_regs import bqf_pkg::*; #(
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output bqf_cfg_t                  cfg
);

  // 1.0 in the coefficient format
  localparam logic signed [COEF_BITS-1:0] COEF_UNITY = COEF_BITS'(1) << COEF_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ff0    <= COEF_UNITY;
      cfg.ff1    <= '0;
      cfg.ff2    <= '0;
      cfg.fb1    <= '0;
      cfg.fb2    <= '0;
      cfg.offset <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEF_FF0:   cfg.ff0    <= cfg_data[COEF_BITS-1:0];
        REG_COEF_FF1:   cfg.ff1    <= cfg_data[COEF_BITS-1:0];
        REG_COEF_FF2:   cfg.ff2    <= cfg_data[COEF_BITS-1:0];
        REG_COEF_FB1:   cfg.fb1    <= cfg_data[COEF_BITS-1:0];
        REG_COEF_FB2:   cfg.fb2    <= cfg_data[COEF_BITS-1:0];
        REG_OUT_OFFSET: cfg.offset <= cfg_data[OFFSET_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/bqf_ff.sv
// feedforward pipeline: input register, input delay line, products and their sum
module bqf_ff import bqf_pkg::*; #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bqf_cfg_t                     cfg,
  output logic                         ff_valid,
  input  logic                         ff_ready,
  output logic signed [((SAMPLE_BITS+COEF_BITS+3 < 64) ? SAMPLE_BITS+COEF_BITS+3 : 64)-1:0]
                                       ff_acc
);

  `include "assert_macros.svh"

  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = (PROD_W + 3 < 64) ? PROD_W + 3 : 64;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  logic v1, v2, v3;
  logic ready1, ready2, ready3;
  logic load1, load2, load3;

  logic signed [SAMPLE_BITS-1:0] in_delay1, in_delay2;
  logic signed [SAMPLE_BITS-1:0] x0, x1, x2;
  logic signed [PROD_W-1:0]      p0, p1, p2;
  logic signed [ACC_W-1:0]       acc;

  // a stage takes a new item when it is empty or its item moves on
  assign ready3   = !v3 || ff_ready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1 && !rst;

  assign load1 = in_valid && in_ready;
  assign load2 = v1 && ready2;
  assign load3 = v2 && ready3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      in_delay1 <= '0;
      in_delay2 <= '0;
    end else begin
      if (ready1) begin
        v1 <= in_valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
      if (load1) begin
        in_delay1 <= sample_in;
        in_delay2 <= in_delay1;
      end
    end
  end

  // the input history is snapshotted with each sample so later stages need no shared state
  always_ff @(posedge clk) begin
    if (load1) begin
      x0 <= sample_in;
      x1 <= in_delay1;
      x2 <= in_delay2;
    end
    if (load2) begin
      p0 <= PROD_W'(x0) * PROD_W'(cfg.ff0);
      p1 <= PROD_W'(x1) * PROD_W'(cfg.ff1);
      p2 <= PROD_W'(x2) * PROD_W'(cfg.ff2);
    end
    if (load3) begin
      acc <= ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2) + ROUND_HALF;
    end
  end

  assign ff_valid = v3;
  assign ff_acc   = acc;

  `BQF_ASSERT_NXT(a_in_delay_shift, clk, rst, load1,
    in_delay2 == $past(in_delay1), "input delay line did not shift on accept")
  `BQF_ASSERT_NXT(a_in_delay_hold, clk, rst, !load1,
    $stable(in_delay1) && $stable(in_delay2), "input delay line moved without a sample")
  `BQF_ASSERT_NXT(a_ff_hold, clk, rst, v3 && !ff_ready,
    v3 && $stable(ff_acc), "feedforward sum lost while feedback stage stalled")

endmodule

>>> hw/rtl/bqf_fb.sv
// feedback stage with output delay line, then offset add into the output register
module bqf_fb import bqf_pkg::*; #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bqf_cfg_t                      cfg,
  input  logic                          ff_valid,
  output logic                          ff_ready,
  input  logic signed [((SAMPLE_BITS+COEF_BITS+3 < 64) ? SAMPLE_BITS+COEF_BITS+3 : 64)-1:0]
                                        ff_acc,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          out_valid,
  input  logic                          out_ready
);

  `include "assert_macros.svh"

  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = (PROD_W + 3 < 64) ? PROD_W + 3 : 64;
  localparam int SH_W   = ACC_W - COEF_FRAC_BITS;
  localparam int SUM_W  = ((SAMPLE_BITS > OFFSET_BITS) ? SAMPLE_BITS : OFFSET_BITS) + 1;

  localparam logic signed [SH_W-1:0]  Y_MAX = {{(SH_W-SAMPLE_BITS+1){1'b0}},
                                               {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SH_W-1:0]  Y_MIN = ~Y_MAX;
  localparam logic signed [SUM_W-1:0] O_MAX = {{(SUM_W-SAMPLE_BITS+1){1'b0}},
                                               {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] O_MIN = ~O_MAX;

  logic v4, v5;
  logic ready4, ready5;
  logic load4, load5;

  logic signed [SAMPLE_BITS-1:0] out_delay1, out_delay2;
  logic signed [SAMPLE_BITS-1:0] out_reg;
  logic signed [PROD_W-1:0]      q1, q2;
  logic signed [ACC_W-1:0]       total;
  logic signed [SH_W-1:0]        shifted;
  logic signed [SAMPLE_BITS-1:0] y_next;
  logic signed [SUM_W-1:0]       osum;
  logic signed [SAMPLE_BITS-1:0] o_next;

  assign ready5   = !v5 || out_ready;
  assign ready4   = !v4 || ready5;
  assign ff_ready = ready4;

  assign load4 = ff_valid && ready4;
  assign load5 = v4 && ready5;

  // recursion: the previous filter value is read back from the delay line
  always_comb begin
    q1      = PROD_W'(out_delay1) * PROD_W'(cfg.fb1);
    q2      = PROD_W'(out_delay2) * PROD_W'(cfg.fb2);
    total   = ff_acc - ACC_W'(q1) - ACC_W'(q2);
    // floor shift: drop the fraction bits
    shifted = total[ACC_W-1:COEF_FRAC_BITS];
    if (shifted > Y_MAX) begin
      y_next = Y_MAX[SAMPLE_BITS-1:0];
    end else if (shifted < Y_MIN) begin
      y_next = Y_MIN[SAMPLE_BITS-1:0];
    end else begin
      y_next = shifted[SAMPLE_BITS-1:0];
    end
  end

  // offset applied to the filter value held in the delay line
  always_comb begin
    osum = SUM_W'(out_delay1) + SUM_W'(cfg.offset);
    if (osum > O_MAX) begin
      o_next = O_MAX[SAMPLE_BITS-1:0];
    end else if (osum < O_MIN) begin
      o_next = O_MIN[SAMPLE_BITS-1:0];
    end else begin
      o_next = osum[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4         <= 1'b0;
      v5         <= 1'b0;
      out_delay1 <= '0;
      out_delay2 <= '0;
    end else begin
      if (ready4) begin
        v4 <= ff_valid;
      end
      if (ready5) begin
        v5 <= v4;
      end
      if (load4) begin
        out_delay1 <= y_next;
        out_delay2 <= out_delay1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load5) begin
      out_reg <= o_next;
    end
  end

  assign sample_out = out_reg;
  assign out_valid  = v5;

  `BQF_ASSERT_NXT(a_out_delay_hold, clk, rst, !load4,
    $stable(out_delay1) && $stable(out_delay2), "output delay line moved without a sample")
  `BQF_ASSERT_NXT(a_zero_offset, clk, rst, load5 && cfg.offset == '0,
    sample_out == $past(out_delay1), "zero offset changed the filter value")
  `BQF_ASSERT_IMP(a_stage_order, clk, rst, v4 && !ready5,
    !ff_ready, "feedback stage overwritten while output stalled")

endmodule

>>> hw/rtl/parametric_boost_biquad_filter_unit.sv
// top level of the second-order direct form I filter with output offset
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_ready    sample_in
//   output    out        out_valid / out_ready  sample_out
//   config    in         cfg_we (no wait)       cfg_index, cfg_data
//
// one sample per cycle sustained while the output is not stalled; a sample passes through
// five register stages (input, products, feedforward sum, feedback, output). the
// recursion closes in the feedback stage: two multiplies, two subtracts, a floor shift
// and saturation, all combinational ahead of the feedback register.
// synchronous reset clears the delay lines, the stage valids and loads the default
// coefficients; a stalled output holds every stage behind it, bubbles are filled.
module parametric_boost_biquad_filter_unit import bqf_pkg::*; #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          in_valid,
  output logic                          in_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = (PROD_W + 3 < 64) ? PROD_W + 3 : 64;

  bqf_cfg_t                cfg;
  logic                    ff_valid;
  logic                    ff_ready;
  logic signed [ACC_W-1:0] ff_acc;

  bqf_regs #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  bqf_ff #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_ff (
    .clk      (clk),
    .rst      (rst),
    .sample_in(sample_in),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cfg      (cfg),
    .ff_valid (ff_valid),
    .ff_ready (ff_ready),
    .ff_acc   (ff_acc)
  );

  bqf_fb #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_fb (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ff_valid  (ff_valid),
    .ff_ready  (ff_ready),
    .ff_acc    (ff_acc),
    .sample_out(sample_out),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

>>> bench/tb_parametric_boost_biquad_filter_unit.sv
// self-checking testbench for the biquad filter unit with output offset
module tb_parametric_boost_biquad_filter_unit import bqf_pkg::*;;

  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 24;
  localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE6 = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE7 = 3'd7;

  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 83;
  localparam int LONG_STALL      = 150;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_LIMIT     = 20000;
  localparam logic [31:0] FF_SPAN = 32'h0200_0000;  // +/-2.0
  localparam logic [31:0] FB_SPAN = 32'h0100_0000;  // +/-1.0

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic signed [SAMPLE_BITS-1:0] sample_in = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0]     cfg_index = REG_COEF_FF0;
  logic [CFG_DATA_BITS-1:0]      cfg_data = '0;

  // filter state and coefficients as the block should hold them
  logic signed [COEF_BITS-1:0]   ff0_q, ff1_q, ff2_q, fb1_q, fb2_q;
  logic signed [OFFSET_BITS-1:0] offset_q;
  logic signed [SAMPLE_BITS-1:0] x1_q, x2_q, y1_q, y2_q;

  logic signed [SAMPLE_BITS-1:0] pending_samples[$];
  logic signed [SAMPLE_BITS-1:0] expected_outputs[$];
  int unsigned samples_queued = 0;
  int unsigned samples_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned send_gap = 0;
  int unsigned ready_stall = 0;
  int unsigned stalls_asked = 0;
  int unsigned stalls_done = 0;
  logic        sender_steady = 1'b0;
  logic        receiver_steady = 1'b0;

  parametric_boost_biquad_filter_unit #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (sample_in),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_out (sample_out),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(longint v);
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    else if (v < SAMPLE_MIN) v = SAMPLE_MIN;
    return SAMPLE_BITS'(v);
  endfunction

  // one filter step: returns the emitted sample and advances the delay lines
  function automatic logic signed [SAMPLE_BITS-1:0] filter_predict(
      logic signed [SAMPLE_BITS-1:0] x);
    longint acc;
    logic signed [SAMPLE_BITS-1:0] y;
    acc = longint'(x) * longint'(ff0_q) + longint'(x1_q) * longint'(ff1_q)
        + longint'(x2_q) * longint'(ff2_q) - longint'(y1_q) * longint'(fb1_q)
        - longint'(y2_q) * longint'(fb2_q);
    // round half up, then floor shift
    acc = acc + (64'sd1 <<< (COEF_FRAC_BITS - 1));
    y = clamp_sample(acc >>> COEF_FRAC_BITS);
    x2_q = x1_q;
    x1_q = x;
    y2_q = y1_q;
    y1_q = y;
    return clamp_sample(longint'(y) + longint'(offset_q));
  endfunction

  function automatic void model_write(logic [CFG_INDEX_BITS-1:0] idx,
                                      logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_COEF_FF0:   ff0_q = data[COEF_BITS-1:0];
      REG_COEF_FF1:   ff1_q = data[COEF_BITS-1:0];
      REG_COEF_FF2:   ff2_q = data[COEF_BITS-1:0];
      REG_COEF_FB1:   fb1_q = data[COEF_BITS-1:0];
      REG_COEF_FB2:   fb2_q = data[COEF_BITS-1:0];
      REG_OUT_OFFSET: offset_q = data[OFFSET_BITS-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_coef(logic [31:0] span);
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return '0;
      default: return $urandom_range(0, 2 * span) - span;
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_offset();
    case ($urandom_range(0, 5))
      0: return 32'h0000_7FFF;
      1: return 32'hFFFF_8000;
      2: return '0;
      3: return $urandom();
      default: return $urandom_range(0, 2048) - 1024;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_BITS'(SAMPLE_MAX);
      1: return SAMPLE_BITS'(SAMPLE_MIN);
      2: return '0;
      3, 4: return SAMPLE_BITS'($urandom_range(0, 512) - 256);
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  task automatic note_mismatch(string what, logic signed [SAMPLE_BITS-1:0] want,
                               logic signed [SAMPLE_BITS-1:0] got);
    if (mismatches < 10)
      $display("mismatch (%s): expected %0d, got %0d", what, want, got);
    mismatches++;
  endtask

  task automatic check_output(logic signed [SAMPLE_BITS-1:0] got);
    logic signed [SAMPLE_BITS-1:0] want;
    if (expected_outputs.size() == 0) begin
      note_mismatch("no sample pending", '0, got);
    end else begin
      want = expected_outputs.pop_front();
      if (got !== want) note_mismatch("sample_out", want, got);
    end
  endtask

  // driver: one transaction at a time from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_outputs.push_back(filter_predict(sample_in));
        samples_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          sample_in <= pending_samples.pop_front();
          in_valid <= 1'b1;
          send_gap <= sender_steady ? 0 : $urandom_range(0, 16);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each output transaction, then draws the next stall
  always @(posedge clk) begin
    int unsigned stall;
    if (rst) begin
      out_ready <= 1'b0;
      ready_stall <= 0;
    end else if (out_valid && out_ready) begin
      check_output(sample_out);
      if (stalls_done != stalls_asked) begin
        stall = LONG_STALL;
        stalls_done <= stalls_done + 1;
      end else begin
        stall = receiver_steady ? 0 : $urandom_range(0, 16);
      end
      out_ready <= (stall == 0);
      ready_stall <= (stall == 0) ? 0 : stall - 1;
    end else if (ready_stall != 0) begin
      ready_stall <= ready_stall - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic offer(logic signed [SAMPLE_BITS-1:0] x);
    pending_samples.push_back(x);
    samples_queued++;
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    model_write(idx, data);
  endtask

  task automatic finish_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for every queued sample to come back, then let the pipeline settle
  task automatic drain();
    int unsigned waited;
    waited = 0;
    while ((samples_accepted != samples_queued || expected_outputs.size() != 0)
           && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    ff0_q = 32'sh0100_0000;
    ff1_q = '0;
    ff2_q = '0;
    fb1_q = '0;
    fb2_q = '0;
    offset_q = '0;
    x1_q = '0;
    x2_q = '0;
    y1_q = '0;
    y2_q = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset coefficients pass samples straight through
    offer('0);
    offer(SAMPLE_BITS'(SAMPLE_MAX));
    offer(SAMPLE_BITS'(SAMPLE_MIN));
    offer(SAMPLE_BITS'(-1));
    offer(SAMPLE_BITS'(1));
    drain();

    // half gain: ties at +/-0.5 round toward plus infinity
    write_reg(REG_COEF_FF0, 32'h0080_0000);
    finish_writes();
    offer(SAMPLE_BITS'(1));
    offer(SAMPLE_BITS'(-1));
    offer(SAMPLE_BITS'(3));
    offer(SAMPLE_BITS'(-3));
    drain();

    // extreme coefficients saturate the filter, offset saturates on top
    write_reg(REG_COEF_FF0, 32'h7FFF_FFFF);
    write_reg(REG_COEF_FF1, 32'h8000_0000);
    write_reg(REG_COEF_FF2, 32'h7FFF_FFFF);
    write_reg(REG_COEF_FB1, 32'h8000_0000);
    write_reg(REG_COEF_FB2, 32'h7FFF_FFFF);
    write_reg(REG_OUT_OFFSET, 32'hABCD_7FFF);  // upper bits ignored
    write_reg(REG_SPARE6, 32'h1234_5678);      // unmapped, ignored
    write_reg(REG_SPARE7, 32'hFFFF_FFFF);
    finish_writes();
    offer(SAMPLE_BITS'(SAMPLE_MAX));
    offer(SAMPLE_BITS'(SAMPLE_MIN));
    offer(SAMPLE_BITS'(SAMPLE_MAX));
    offer(SAMPLE_BITS'(SAMPLE_MIN));
    offer(SAMPLE_BITS'(1));
    offer('0);
    drain();

    // most negative gain and offset
    write_reg(REG_COEF_FF0, 32'h8000_0000);
    write_reg(REG_COEF_FF1, '0);
    write_reg(REG_COEF_FF2, '0);
    write_reg(REG_COEF_FB1, '0);
    write_reg(REG_COEF_FB2, '0);
    write_reg(REG_OUT_OFFSET, 32'h1234_8000);
    finish_writes();
    offer(SAMPLE_BITS'(SAMPLE_MAX));
    offer(SAMPLE_BITS'(SAMPLE_MIN));
    offer(SAMPLE_BITS'(100));
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_reg(REG_COEF_FF0, pick_coef(FF_SPAN));
      write_reg(REG_COEF_FF1, pick_coef(FF_SPAN));
      write_reg(REG_COEF_FF2, pick_coef(FF_SPAN));
      write_reg(REG_COEF_FB1, pick_coef(FB_SPAN));
      write_reg(REG_COEF_FB2, pick_coef(FB_SPAN));
      write_reg(REG_OUT_OFFSET, pick_offset());
      if ($urandom_range(0, 2) == 0)
        write_reg(phase[0] ? REG_SPARE7 : REG_SPARE6, $urandom());
      finish_writes();
      sender_steady <= (phase % 3 == 1);
      receiver_steady <= (phase % 4 == 3);
      // back-to-back input against a long output stall fills the pipeline
      if (phase % 3 == 1) stalls_asked <= stalls_asked + 1;
      repeat (ITEMS_PER_PHASE) offer(random_sample());
      drain();
    end

    if (mismatches == 0 && expected_outputs.size() == 0 && samples_accepted == samples_queued)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/bqf_pkg.sv
hw/rtl/bqf_regs.sv
hw/rtl/bqf_ff.sv
hw/rtl/bqf_fb.sv
hw/rtl/parametric_boost_biquad_filter_unit.sv
bench/tb_parametric_boost_biquad_filter_unit.sv
